// ===== hdl/mer_pkg.sv =====
// shared constants, command and status types of the midpoint ellipse rasterizer
package mer_pkg;

  localparam int RB_DEF = 10;
  localparam int CB_DEF = 11;

  localparam logic OP_START = 1'b0;

  // operand pairs of the shared multiplier
  typedef enum logic [3:0] {
    MUL_A_A     = 4'd0,
    MUL_B_B     = 4'd1,
    MUL_AA_B    = 4'd2,
    MUL_AA_2YM1 = 4'd3,
    MUL_BB_XP1  = 4'd4,
    MUL_BB_2XP3 = 4'd5,
    MUL_AA_YM1  = 4'd6,
    MUL_SQ_2XP1 = 4'd7,
    MUL_BB_P    = 4'd8,
    MUL_SQ_YM1  = 4'd9,
    MUL_AA_P    = 4'd10,
    MUL_AA_BB   = 4'd11,
    MUL_AA_2YM3 = 4'd12
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic     start_ld;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     cap_aa;
    logic     cap_bb;
    logic     cap_tmp;
    acc_op_t  acc_op;
    logic [1:0] acc_sh;
    logic     inc_x;
    logic     dec_y;
    logic     set_r2;
    logic     out_ld;
    logic     out_null;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic second;
    logic dec_neg;
    logic r1_go;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/mer_ctrl.sv =====
// sequencer of the midpoint ellipse rasterizer
module mer_ctrl import mer_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_opcode,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_S0   = 20'h00002,
    ST_S1   = 20'h00004,
    ST_S2   = 20'h00008,
    ST_S3   = 20'h00010,
    ST_T0   = 20'h00020,
    ST_T1   = 20'h00040,
    ST_T2   = 20'h00080,
    ST_U1   = 20'h00100,
    ST_U2   = 20'h00200,
    ST_Q0   = 20'h00400,
    ST_Q1   = 20'h00800,
    ST_Q2   = 20'h01000,
    ST_Q3   = 20'h02000,
    ST_Q4   = 20'h04000,
    ST_Q5   = 20'h08000,
    ST_V0   = 20'h10000,
    ST_V1   = 20'h20000,
    ST_V2   = 20'h40000,
    ST_EMIT = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  logic   null_r, null_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    null_nxt  = null_r;
    cmd       = '0;
    cmd.mul_sel = MUL_A_A;
    cmd.acc_op  = ACC_HOLD;
    cmd.out_null = null_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          null_nxt = 1'b0;
          if (in_opcode == OP_START) begin
            cmd.start_ld = 1'b1;
            state_nxt    = ST_S0;
          end else if (!sts.busy) begin
            null_nxt  = 1'b1;
            state_nxt = ST_EMIT;
          end else if (sts.second) begin
            state_nxt = ST_V0;
          end else begin
            state_nxt = ST_T0;
          end
        end
      end
      // start: decision = aa + 4bb - 4aab
      ST_S0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A_A;
        state_nxt   = ST_S1;
      end
      ST_S1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B_B;
        cmd.cap_aa  = 1'b1;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = ST_S2;
      end
      ST_S2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AA_B;
        cmd.cap_bb  = 1'b1;
        cmd.acc_op  = ACC_ADD;
        cmd.acc_sh  = 2'd2;
        state_nxt   = ST_S3;
      end
      ST_S3: begin
        cmd.acc_op = ACC_SUB;
        cmd.acc_sh = 2'd2;
        state_nxt  = ST_EMIT;
      end
      // region 1 test: aa*(2y-1) > 2*bb*(x+1)
      ST_T0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AA_2YM1;
        state_nxt   = ST_T1;
      end
      ST_T1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BB_XP1;
        cmd.cap_tmp = 1'b1;
        state_nxt   = ST_T2;
      end
      ST_T2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BB_2XP3;
        state_nxt   = sts.r1_go ? ST_U1 : ST_Q0;
      end
      // region 1 step, sign taken from the decision before the update
      ST_U1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AA_YM1;
        cmd.acc_op  = ACC_ADD;
        cmd.acc_sh  = 2'd2;
        if (sts.dec_neg) begin
          cmd.inc_x = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_U2;
        end
      end
      ST_U2: begin
        cmd.acc_op = ACC_SUB;
        cmd.acc_sh = 2'd3;
        cmd.inc_x  = 1'b1;
        cmd.dec_y  = 1'b1;
        state_nxt  = ST_EMIT;
      end
      // region 2 entry: bb*(2x+1)^2 + 4aa*(y-1)^2 - 4aabb
      ST_Q0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ_2XP1;
        state_nxt   = ST_Q1;
      end
      ST_Q1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BB_P;
        state_nxt   = ST_Q2;
      end
      ST_Q2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ_YM1;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = ST_Q3;
      end
      ST_Q3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AA_P;
        state_nxt   = ST_Q4;
      end
      ST_Q4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AA_BB;
        cmd.acc_op  = ACC_ADD;
        cmd.acc_sh  = 2'd2;
        state_nxt   = ST_Q5;
      end
      ST_Q5: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AA_2YM3;
        cmd.acc_op  = ACC_SUB;
        cmd.acc_sh  = 2'd2;
        cmd.set_r2  = 1'b1;
        state_nxt   = ST_V1;
      end
      // region 2 step
      ST_V0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AA_2YM3;
        state_nxt   = ST_V1;
      end
      ST_V1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BB_XP1;
        cmd.acc_op  = ACC_SUB;
        cmd.acc_sh  = 2'd2;
        if (sts.dec_neg) begin
          state_nxt = ST_V2;
        end else begin
          cmd.dec_y = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_V2: begin
        cmd.acc_op = ACC_ADD;
        cmd.acc_sh = 2'd3;
        cmd.inc_x  = 1'b1;
        cmd.dec_y  = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      null_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      null_r  <= null_nxt;
    end
  end

endmodule

// ===== hdl/mer_datapath.sv =====
// offsets, decision accumulator, shared multiplier and output word register
module mer_datapath import mer_pkg::*; #(
  parameter int RADIUS_BITS = RB_DEF,
  parameter int COORD_BITS  = CB_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output status_t                       sts,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius_a,
  input  logic [RADIUS_BITS-1:0]        in_radius_b,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [COORD_BITS:0]    out_p0_x,
  output logic signed [COORD_BITS:0]    out_p0_y,
  output logic signed [COORD_BITS:0]    out_p1_x,
  output logic signed [COORD_BITS:0]    out_p1_y,
  output logic signed [COORD_BITS:0]    out_p2_x,
  output logic signed [COORD_BITS:0]    out_p2_y,
  output logic signed [COORD_BITS:0]    out_p3_x,
  output logic signed [COORD_BITS:0]    out_p3_y,
  output logic                          out_last_step,
  output logic                          out_valid_res
);

  localparam int LHS_W = 2 * RADIUS_BITS + 1;
  localparam int RHS_W = 2 * RADIUS_BITS + 5;
  localparam int DEC_W = LHS_W + RHS_W;
  localparam int PT_W  = COORD_BITS + 1;
  localparam int SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  logic signed [COORD_BITS-1:0]  cx_r, cy_r;
  logic [RADIUS_BITS-1:0]        ra_r, rb_r;
  logic [RADIUS_BITS-1:0]        x_r, y_r;
  logic [2*RADIUS_BITS-1:0]      aa_r, bb_r;
  logic signed [DEC_W-1:0]       prod_r, tmp_r, dec_r, dec_nxt;
  logic                          busy_r, second_r;

  logic signed [PT_W-1:0]        p0x_r, p0y_r, p1x_r, p1y_r, p2x_r, p2y_r, p3x_r, p3y_r;
  logic                          last_r, vres_r, ovld_r;

  // operand terms, y >= 1 whenever they are used
  logic [RADIUS_BITS-1:0]        ym1;
  logic [RADIUS_BITS:0]          xp1, y2m1;
  logic [RADIUS_BITS+1:0]        x2p1, x2p3;
  logic signed [RADIUS_BITS+1:0] y2m3;

  logic signed [LHS_W-1:0]       lhs;
  logic signed [RHS_W-1:0]       rhs;
  logic signed [DEC_W-1:0]       mul_p, sh_p;
  logic signed [DEC_W:0]         tmp_e, dbl_e;

  logic signed [SUM_W-1:0]       cx_e, cy_e, x_e, y_e, sx_p, sx_m, sy_p, sy_m;
  logic                          y_zero;

  assign ym1  = y_r - RADIUS_BITS'(1);
  assign xp1  = {1'b0, x_r} + (RADIUS_BITS+1)'(1);
  assign y2m1 = {ym1, 1'b1};
  assign x2p1 = {1'b0, x_r, 1'b1};
  assign x2p3 = x2p1 + (RADIUS_BITS+2)'(2);
  assign y2m3 = $signed({1'b0, ym1, 1'b0}) - $signed((RADIUS_BITS+2)'(1));

  always_comb begin
    lhs = '0;
    rhs = '0;
    unique case (cmd.mul_sel)
      MUL_A_A:     begin lhs = LHS_W'(ra_r); rhs = RHS_W'(ra_r); end
      MUL_B_B:     begin lhs = LHS_W'(rb_r); rhs = RHS_W'(rb_r); end
      MUL_AA_B:    begin lhs = LHS_W'(aa_r); rhs = RHS_W'(rb_r); end
      MUL_AA_2YM1: begin lhs = LHS_W'(aa_r); rhs = RHS_W'(y2m1); end
      MUL_BB_XP1:  begin lhs = LHS_W'(bb_r); rhs = RHS_W'(xp1);  end
      MUL_BB_2XP3: begin lhs = LHS_W'(bb_r); rhs = RHS_W'(x2p3); end
      MUL_AA_YM1:  begin lhs = LHS_W'(aa_r); rhs = RHS_W'(ym1);  end
      MUL_SQ_2XP1: begin lhs = LHS_W'(x2p1); rhs = RHS_W'(x2p1); end
      MUL_BB_P:    begin lhs = LHS_W'(bb_r); rhs = prod_r[RHS_W-1:0]; end
      MUL_SQ_YM1:  begin lhs = LHS_W'(ym1);  rhs = RHS_W'(ym1);  end
      MUL_AA_P:    begin lhs = LHS_W'(aa_r); rhs = prod_r[RHS_W-1:0]; end
      MUL_AA_BB:   begin lhs = LHS_W'(aa_r); rhs = RHS_W'(bb_r); end
      MUL_AA_2YM3: begin lhs = LHS_W'(aa_r); rhs = RHS_W'(y2m3); end
      default:     begin lhs = '0; rhs = '0; end
    endcase
  end

  assign mul_p = lhs * rhs;
  assign sh_p  = prod_r <<< cmd.acc_sh;

  always_comb begin
    unique case (cmd.acc_op)
      ACC_HOLD: dec_nxt = dec_r;
      ACC_LOAD: dec_nxt = prod_r;
      ACC_ADD:  dec_nxt = dec_r + sh_p;
      ACC_SUB:  dec_nxt = dec_r - sh_p;
    endcase
  end

  assign tmp_e = (DEC_W+1)'(tmp_r);
  assign dbl_e = $signed({prod_r, 1'b0});

  assign cx_e = SUM_W'(cx_r);
  assign cy_e = SUM_W'(cy_r);
  assign x_e  = $signed(SUM_W'(x_r));
  assign y_e  = $signed(SUM_W'(y_r));
  assign sx_p = cx_e + x_e;
  assign sx_m = cx_e - x_e;
  assign sy_p = cy_e + y_e;
  assign sy_m = cy_e - y_e;
  assign y_zero = (y_r == '0);

  assign sts.busy     = busy_r;
  assign sts.second   = second_r;
  assign sts.dec_neg  = dec_r[DEC_W-1];
  assign sts.r1_go    = (tmp_e > dbl_e);
  assign sts.out_free = !ovld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.start_ld) begin
      cx_r <= in_center_x;
      cy_r <= in_center_y;
      ra_r <= in_radius_a;
      rb_r <= in_radius_b;
      x_r  <= '0;
      y_r  <= in_radius_b;
    end else begin
      if (cmd.inc_x) x_r <= x_r + RADIUS_BITS'(1);
      if (cmd.dec_y) y_r <= y_r - RADIUS_BITS'(1);
    end
    if (cmd.mul_en)  prod_r <= mul_p;
    if (cmd.cap_aa)  aa_r   <= prod_r[2*RADIUS_BITS-1:0];
    if (cmd.cap_bb)  bb_r   <= prod_r[2*RADIUS_BITS-1:0];
    if (cmd.cap_tmp) tmp_r  <= prod_r;
    dec_r <= dec_nxt;
    if (cmd.out_ld) begin
      if (cmd.out_null) begin
        p0x_r  <= '0;
        p0y_r  <= '0;
        p1x_r  <= '0;
        p1y_r  <= '0;
        p2x_r  <= '0;
        p2y_r  <= '0;
        p3x_r  <= '0;
        p3y_r  <= '0;
        last_r <= 1'b0;
        vres_r <= 1'b0;
      end else begin
        p0x_r  <= sx_p[PT_W-1:0];
        p0y_r  <= sy_p[PT_W-1:0];
        p1x_r  <= sx_m[PT_W-1:0];
        p1y_r  <= sy_p[PT_W-1:0];
        p2x_r  <= sx_m[PT_W-1:0];
        p2y_r  <= sy_m[PT_W-1:0];
        p3x_r  <= sx_p[PT_W-1:0];
        p3y_r  <= sy_m[PT_W-1:0];
        last_r <= y_zero;
        vres_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      second_r <= 1'b0;
      ovld_r   <= 1'b0;
    end else begin
      if (cmd.start_ld) begin
        busy_r   <= 1'b1;
        second_r <= 1'b0;
      end else begin
        // the step that reaches y = 0 ends the ellipse
        if (cmd.out_ld && !cmd.out_null && y_zero) busy_r <= 1'b0;
        if (cmd.set_r2) second_r <= 1'b1;
      end
      if (cmd.out_ld) begin
        ovld_r <= 1'b1;
      end else if (!out_stall) begin
        ovld_r <= 1'b0;
      end
    end
  end

  assign out_valid     = ovld_r;
  assign out_p0_x      = p0x_r;
  assign out_p0_y      = p0y_r;
  assign out_p1_x      = p1x_r;
  assign out_p1_y      = p1y_r;
  assign out_p2_x      = p2x_r;
  assign out_p2_y      = p2y_r;
  assign out_p3_x      = p3x_r;
  assign out_p3_y      = p3y_r;
  assign out_last_step = last_r;
  assign out_valid_res = vres_r;

endmodule

// ===== hdl/midpoint_ellipse_rasterizer.sv =====
// midpoint ellipse rasterizer, top level
//
// Input channel (in_valid / in_stall): one word per command. opcode 0 starts an
// ellipse from center and radii and yields the step at (0, b); opcode 1 yields
// the next step. An advance with no ellipse running gives a word with
// valid_res = 0 and all other fields zero.
// Output channel (out_valid / out_stall): one word per command, holding the
// four symmetric points and last_step, set when the offset y reaches 0.
// One command is worked at a time on a single shared multiplier; in_stall is
// high from acceptance until the result word is loaded into the output
// register. Each start or step runs the multiply-accumulate sequence of
// that step, and the result word is loaded in the emit state that follows.
// A stalled result word is held; the block then waits with in_stall high.
// Synchronous reset (rst_n low) leaves the block idle with no word pending.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int RADIUS_BITS = RB_DEF,
  parameter int COORD_BITS  = CB_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic signed [COORD_BITS-1:0]  in_center_x,
  input  logic signed [COORD_BITS-1:0]  in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius_a,
  input  logic [RADIUS_BITS-1:0]        in_radius_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS:0]    out_p0_x,
  output logic signed [COORD_BITS:0]    out_p0_y,
  output logic signed [COORD_BITS:0]    out_p1_x,
  output logic signed [COORD_BITS:0]    out_p1_y,
  output logic signed [COORD_BITS:0]    out_p2_x,
  output logic signed [COORD_BITS:0]    out_p2_y,
  output logic signed [COORD_BITS:0]    out_p3_x,
  output logic signed [COORD_BITS:0]    out_p3_y,
  output logic                          out_last_step,
  output logic                          out_valid_res
);

  cmd_t    cmd;
  status_t sts;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_radius_a   (in_radius_a),
    .in_radius_b   (in_radius_b),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_p0_x      (out_p0_x),
    .out_p0_y      (out_p0_y),
    .out_p1_x      (out_p1_x),
    .out_p1_y      (out_p1_y),
    .out_p2_x      (out_p2_x),
    .out_p2_y      (out_p2_y),
    .out_p3_x      (out_p3_x),
    .out_p3_y      (out_p3_y),
    .out_last_step (out_last_step),
    .out_valid_res (out_valid_res)
  );

endmodule

// ===== hdl/mer_checker.sv =====
// port-level checks of the midpoint ellipse rasterizer and their bind
module mer_checker import mer_pkg::*; #(
  parameter int COORD_BITS = CB_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [COORD_BITS:0] out_p0_x,
  input logic signed [COORD_BITS:0] out_p0_y,
  input logic signed [COORD_BITS:0] out_p1_x,
  input logic signed [COORD_BITS:0] out_p1_y,
  input logic signed [COORD_BITS:0] out_p2_x,
  input logic signed [COORD_BITS:0] out_p2_y,
  input logic signed [COORD_BITS:0] out_p3_x,
  input logic signed [COORD_BITS:0] out_p3_y,
  input logic                       out_last_step,
  input logic                       out_valid_res
);

  // one command in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a command is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output word dropped");

  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |->
      out_p0_x == '0 && out_p0_y == '0 && out_p1_x == '0 && out_p1_y == '0 &&
      out_p2_x == '0 && out_p2_y == '0 && out_p3_x == '0 && out_p3_y == '0 &&
      !out_last_step)
    else $error("idle advance word not all zero");

  a_symmetry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |->
      out_p0_x == out_p3_x && out_p1_x == out_p2_x &&
      out_p0_y == out_p1_y && out_p2_y == out_p3_y)
    else $error("points not symmetric about the center");

  a_last_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res && out_last_step |-> out_p0_y == out_p2_y)
    else $error("last step with nonzero y offset");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
  .COORD_BITS (COORD_BITS)
) u_mer_checker (.*);
